/* rtl/core/timed_slot_pool_lru_evict_assert.svh */
// Assertion macros for the timed slot pool.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef TIMED_SLOT_POOL_LRU_EVICT_ASSERT_SVH
`define TIMED_SLOT_POOL_LRU_EVICT_ASSERT_SVH

// Same-cycle implication
`define TSPL_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("timed slot pool: same-cycle check failed");

// Next-cycle implication
`define TSPL_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("timed slot pool: next-cycle check failed");

`endif

/* rtl/core/tspl_pkg.sv */
`default_nettype none
package tspl_pkg;

   // field widths of the stream items
   localparam int ACTION_W     = 2;
   localparam int SLOT_FIELD_W = 11;
   localparam int TIME_FIELD_W = 31;
   localparam int CNT_FIELD_W  = 12;
   localparam int REQ_DATA_W   = 80;
   localparam int RSP_DATA_W   = 48;

   // action codes on req_tuser
   localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SWEEP = 2'd2;

   // classified operations handed to the engine
   typedef logic [2:0] op_type;
   localparam op_type OP_NOP      = 3'd0;
   localparam op_type OP_ALLOC    = 3'd1;
   localparam op_type OP_FREE     = 3'd2;
   localparam op_type OP_FREE_BAD = 3'd3;
   localparam op_type OP_SWEEP    = 3'd4;

   // command queue between front and engine
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;

   typedef struct packed {
      op_type                  op;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [TIME_FIELD_W-1:0] expiry;
      logic [TIME_FIELD_W-1:0] now;
   } tspl_cmd_type;

endpackage
`default_nettype wire

/* rtl/core/tspl_front.sv */
`default_nettype none
module tspl_front #(
   parameter int POOL_SLOTS = 2048
) (
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [tspl_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire logic [tspl_pkg::ACTION_W-1:0]    req_tuser,
   output logic                                  cmd_valid,
   input  wire logic                             cmd_ready,
   output tspl_pkg::tspl_cmd_type                cmd
);

   logic slot_in_range;

   // free of a slot outside the pool is settled here
   assign slot_in_range = 32'(req_tdata[10:0]) < 32'(POOL_SLOTS);

   // classify the action
   always_comb begin
      cmd.slot   = req_tdata[10:0];
      cmd.expiry = req_tdata[41:11];
      cmd.now    = req_tdata[72:42];
      unique case (req_tuser)
         tspl_pkg::ACT_ALLOC: cmd.op = tspl_pkg::OP_ALLOC;
         tspl_pkg::ACT_FREE:  cmd.op = slot_in_range ? tspl_pkg::OP_FREE
                                                     : tspl_pkg::OP_FREE_BAD;
         tspl_pkg::ACT_SWEEP: cmd.op = tspl_pkg::OP_SWEEP;
         default:             cmd.op = tspl_pkg::OP_NOP;
      endcase
   end

   assign cmd_valid  = req_tvalid;
   assign req_tready = cmd_ready;

endmodule
`default_nettype wire

/* rtl/core/tspl_queue.sv */
`default_nettype none
module tspl_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire tspl_pkg::tspl_cmd_type in_cmd,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output tspl_pkg::tspl_cmd_type      out_cmd
);

   tspl_pkg::tspl_cmd_type             slot_ff [tspl_pkg::QUEUE_DEPTH];
   logic [tspl_pkg::QPTR_W-1:0]        wr_ptr_ff;
   logic [tspl_pkg::QPTR_W-1:0]        rd_ptr_ff;
   logic [tspl_pkg::QPTR_W:0]          count_ff;
   logic                               push;
   logic                               pop;

   assign in_ready  = count_ff != (tspl_pkg::QPTR_W+1)'(tspl_pkg::QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_cmd   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= in_cmd;
   end

endmodule
`default_nettype wire

/* rtl/core/tspl_engine.sv */
`default_nettype none
module tspl_engine #(
   parameter int POOL_SLOTS = 2048,
   parameter int TIME_BITS  = 31
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             cmd_valid,
   output logic                                  cmd_ready,
   input  wire tspl_pkg::tspl_cmd_type           cmd,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [tspl_pkg::RSP_DATA_W-1:0]       rsp_tdata
);

   localparam int IDX_W  = $clog2(POOL_SLOTS);
   localparam int LINK_W = $clog2(POOL_SLOTS + 1);
   localparam int EXP_W  = (TIME_BITS < tspl_pkg::TIME_FIELD_W) ? TIME_BITS
                                                                : tspl_pkg::TIME_FIELD_W;
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_SLOTS);

   // sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_RD    = 4'd1;
   localparam logic [3:0] ST_CHK   = 4'd2;
   localparam logic [3:0] ST_REL1  = 4'd3;
   localparam logic [3:0] ST_REL2  = 4'd4;
   localparam logic [3:0] ST_SWP   = 4'd5;
   localparam logic [3:0] ST_ALLOC = 4'd6;
   localparam logic [3:0] ST_POP   = 4'd7;
   localparam logic [3:0] ST_LINKA = 4'd8;
   localparam logic [3:0] ST_LINKB = 4'd9;
   localparam logic [3:0] ST_DONE  = 4'd10;

   // slot tables
   logic [LINK_W-1:0] next_mem_ff [POOL_SLOTS];
   logic [LINK_W-1:0] prev_mem_ff [POOL_SLOTS];
   logic              act_mem_ff  [POOL_SLOTS];
   logic [EXP_W-1:0]  exp_mem_ff  [POOL_SLOTS];
   logic [LINK_W-1:0] next_rd_ff;
   logic [LINK_W-1:0] prev_rd_ff;
   logic              act_rd_ff;
   logic [EXP_W-1:0]  exp_rd_ff;

   // control state
   logic [3:0]             state_ff;
   tspl_pkg::tspl_cmd_type cmd_ff;
   logic [IDX_W-1:0]       t_ff;
   logic [IDX_W-1:0]       s_ff;
   logic [LINK_W-1:0]      newer_ff;
   logic [LINK_W-1:0]      older_ff;
   logic [LINK_W-1:0]      cur_ff;
   logic [LINK_W-1:0]      free_head_ff;
   logic [LINK_W-1:0]      fresh_ff;
   logic [LINK_W-1:0]      newest_ff;
   logic [LINK_W-1:0]      oldest_ff;
   logic [LINK_W-1:0]      count_ff;
   logic [LINK_W-1:0]      freed_ff;
   logic [IDX_W-1:0]       granted_ff;
   logic                   evicted_ff;
   logic [IDX_W-1:0]       ev_slot_ff;
   logic                   status_ff;
   logic                   rsp_valid_ff;
   logic [tspl_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   // memory port controls
   logic [IDX_W-1:0]  next_ra;
   logic              next_we, prev_we, act_we, exp_we;
   logic [IDX_W-1:0]  next_wa, prev_wa, act_wa;
   logic [LINK_W-1:0] next_wd, prev_wd;
   logic              act_wd;
   logic              pool_full;
   logic              evict_now;

   assign cmd_ready  = state_ff == ST_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign pool_full  = (free_head_ff == NULL_LINK) && (fresh_ff == NULL_LINK);
   assign next_ra    = (state_ff == ST_ALLOC) ? free_head_ff[IDX_W-1:0] : t_ff;
   // allocate into a full pool first evicts the oldest slot
   assign evict_now  = (cmd.op == tspl_pkg::OP_ALLOC) && pool_full && (oldest_ff != NULL_LINK);

   // write port selection
   always_comb begin
      next_we = 1'b0;
      next_wa = t_ff;
      next_wd = free_head_ff;
      prev_we = 1'b0;
      prev_wa = t_ff;
      prev_wd = NULL_LINK;
      act_we  = 1'b0;
      act_wa  = t_ff;
      act_wd  = 1'b0;
      exp_we  = 1'b0;
      unique case (state_ff)
         ST_REL1: begin
            // unlink from the age list
            if (newer_ff != NULL_LINK) begin
               next_we = 1'b1;
               next_wa = newer_ff[IDX_W-1:0];
               next_wd = older_ff;
            end
            if (older_ff != NULL_LINK) begin
               prev_we = 1'b1;
               prev_wa = older_ff[IDX_W-1:0];
               prev_wd = newer_ff;
            end
            act_we = 1'b1;
         end
         ST_REL2: begin
            // push on the free stack
            next_we = 1'b1;
         end
         ST_LINKA: begin
            if (newest_ff != NULL_LINK) begin
               prev_we = 1'b1;
               prev_wa = newest_ff[IDX_W-1:0];
               prev_wd = LINK_W'(s_ff);
            end
         end
         ST_LINKB: begin
            next_we = 1'b1;
            next_wa = s_ff;
            next_wd = newest_ff;
            prev_we = 1'b1;
            prev_wa = s_ff;
            act_we  = 1'b1;
            act_wa  = s_ff;
            act_wd  = 1'b1;
            exp_we  = 1'b1;
         end
         default: ;
      endcase
   end

   // slot tables, registered reads
   always_ff @(posedge clock) begin
      if (next_we) next_mem_ff[next_wa] <= next_wd;
      if (prev_we) prev_mem_ff[prev_wa] <= prev_wd;
      if (act_we)  act_mem_ff[act_wa]   <= act_wd;
      if (exp_we)  exp_mem_ff[s_ff]     <= cmd_ff.expiry[EXP_W-1:0];
      next_rd_ff <= next_mem_ff[next_ra];
      prev_rd_ff <= prev_mem_ff[t_ff];
      act_rd_ff  <= act_mem_ff[t_ff];
      exp_rd_ff  <= exp_mem_ff[t_ff];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_head_ff <= NULL_LINK;
         fresh_ff     <= '0;
         newest_ff    <= NULL_LINK;
         oldest_ff    <= NULL_LINK;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != ST_DONE) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff     <= cmd;
                  granted_ff <= '0;
                  evicted_ff <= evict_now;
                  ev_slot_ff <= evict_now ? oldest_ff[IDX_W-1:0] : '0;
                  status_ff  <= cmd.op == tspl_pkg::OP_FREE_BAD;
                  freed_ff   <= '0;
                  unique case (cmd.op)
                     tspl_pkg::OP_ALLOC: begin
                        if (evict_now) begin
                           // make room by evicting the oldest slot
                           t_ff     <= oldest_ff[IDX_W-1:0];
                           state_ff <= ST_RD;
                        end else begin
                           state_ff <= ST_ALLOC;
                        end
                     end
                     tspl_pkg::OP_FREE: begin
                        t_ff     <= IDX_W'(cmd.slot);
                        state_ff <= ST_RD;
                     end
                     tspl_pkg::OP_FREE_BAD: state_ff <= ST_DONE;
                     tspl_pkg::OP_SWEEP: begin
                        cur_ff   <= oldest_ff;
                        state_ff <= ST_SWP;
                     end
                     default: state_ff <= ST_DONE;
                  endcase
               end
            end
            ST_RD: state_ff <= ST_CHK;
            ST_CHK: begin
               newer_ff <= prev_rd_ff;
               older_ff <= next_rd_ff;
               unique case (cmd_ff.op)
                  tspl_pkg::OP_FREE: begin
                     // slots at or beyond the fresh mark were never allocated
                     if (act_rd_ff && (LINK_W'(t_ff) < fresh_ff)) begin
                        state_ff <= ST_REL1;
                     end else begin
                        status_ff <= 1'b1;
                        state_ff  <= ST_DONE;
                     end
                  end
                  tspl_pkg::OP_SWEEP: begin
                     if (exp_rd_ff <= cmd_ff.now[EXP_W-1:0]) begin
                        freed_ff <= freed_ff + 1'b1;
                        state_ff <= ST_REL1;
                     end else begin
                        cur_ff   <= prev_rd_ff;
                        state_ff <= ST_SWP;
                     end
                  end
                  default: state_ff <= ST_REL1;
               endcase
            end
            ST_REL1: begin
               if (newer_ff == NULL_LINK) newest_ff <= older_ff;
               if (older_ff == NULL_LINK) oldest_ff <= newer_ff;
               state_ff <= ST_REL2;
            end
            ST_REL2: begin
               free_head_ff <= LINK_W'(t_ff);
               if (count_ff != '0) count_ff <= count_ff - 1'b1;
               unique case (cmd_ff.op)
                  tspl_pkg::OP_ALLOC: state_ff <= ST_ALLOC;
                  tspl_pkg::OP_SWEEP: begin
                     cur_ff   <= newer_ff;
                     state_ff <= ST_SWP;
                  end
                  default: state_ff <= ST_DONE;
               endcase
            end
            ST_SWP: begin
               if (cur_ff == NULL_LINK) begin
                  state_ff <= ST_DONE;
               end else begin
                  t_ff     <= cur_ff[IDX_W-1:0];
                  state_ff <= ST_RD;
               end
            end
            ST_ALLOC: begin
               // free stack first, then untouched slots in order
               if (free_head_ff != NULL_LINK) begin
                  s_ff     <= free_head_ff[IDX_W-1:0];
                  state_ff <= ST_POP;
               end else if (fresh_ff != NULL_LINK) begin
                  s_ff     <= fresh_ff[IDX_W-1:0];
                  fresh_ff <= fresh_ff + 1'b1;
                  state_ff <= ST_LINKA;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_POP: begin
               free_head_ff <= next_rd_ff;
               state_ff     <= ST_LINKA;
            end
            ST_LINKA: state_ff <= ST_LINKB;
            ST_LINKB: begin
               if (newest_ff == NULL_LINK) oldest_ff <= LINK_W'(s_ff);
               newest_ff  <= LINK_W'(s_ff);
               count_ff   <= count_ff + 1'b1;
               granted_ff <= s_ff;
               state_ff   <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {tspl_pkg::CNT_FIELD_W'(count_ff),
                                   tspl_pkg::CNT_FIELD_W'(freed_ff),
                                   status_ff,
                                   tspl_pkg::SLOT_FIELD_W'(ev_slot_ff),
                                   evicted_ff,
                                   tspl_pkg::SLOT_FIELD_W'(granted_ff)};
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

/* rtl/core/timed_slot_pool_lru_evict.sv */
// An allocate takes a recycled slot from the free stack, else an untouched one, and first
// evicts the oldest slot when the pool is full; a free of a slot that is not live is rejected;
// a sweep walks the age list from the oldest slot and frees every slot that has expired.
// Throughput: one item at a time in the engine, the next taken the cycle after a result is
// posted; a two-entry queue takes items while the engine works.
// Reset (synchronous, active high) empties the pool at once; no clearing pass.
`default_nettype none
module timed_slot_pool_lru_evict #(
   parameter int POOL_SLOTS = 2048,
   parameter int TIME_BITS  = 31
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // slot_index[10:0], expiry_time[41:11], now_time[72:42], zero fill
   input  wire logic [tspl_pkg::REQ_DATA_W-1:0]  req_tdata,
   // action[1:0]
   input  wire logic [tspl_pkg::ACTION_W-1:0]    req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // granted_slot[10:0], evicted[11], evicted_slot[22:12], status[23],
   // freed_count[35:24], live_count[47:36]
   output logic [tspl_pkg::RSP_DATA_W-1:0]       rsp_tdata
);

   tspl_pkg::tspl_cmd_type front_cmd;
   tspl_pkg::tspl_cmd_type queue_cmd;
   logic front_valid, front_ready;
   logic queue_valid, queue_ready;

   tspl_front #(.POOL_SLOTS(POOL_SLOTS)) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (front_valid),
      .cmd_ready  (front_ready),
      .cmd        (front_cmd)
   );

   tspl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_cmd    (front_cmd),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_cmd   (queue_cmd)
   );

   tspl_engine #(.POOL_SLOTS(POOL_SLOTS), .TIME_BITS(TIME_BITS)) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (queue_valid),
      .cmd_ready  (queue_ready),
      .cmd        (queue_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

/* rtl/core/tspl_checker.sv */
`default_nettype none
`include "timed_slot_pool_lru_evict_assert.svh"
module tspl_checker #(
   parameter int POOL_SLOTS = 2048
) (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [tspl_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // a stalled result holds
   `TSPL_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // live count never exceeds the pool
   `TSPL_ASSERT_NOW(a_live_bound, rsp_tvalid, rsp_tdata[47:36] <= 12'(POOL_SLOTS))
   // an eviction leaves the pool full
   `TSPL_ASSERT_NOW(a_evict_full, rsp_tvalid && rsp_tdata[11], rsp_tdata[47:36] == 12'(POOL_SLOTS))
   // an error result carries no grant, eviction or sweep count
   `TSPL_ASSERT_NOW(a_err_clean, rsp_tvalid && rsp_tdata[23], rsp_tdata[22:0] == 23'd0 && rsp_tdata[35:24] == 12'd0)

endmodule

bind timed_slot_pool_lru_evict tspl_checker #(.POOL_SLOTS(POOL_SLOTS)) u_tspl_checker (.*);
`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
`default_nettype none
module testbench;

   localparam int SLOTS = 2048;
   localparam int NIL = SLOTS;
   localparam logic [tspl_pkg::ACTION_W-1:0] ACT_UNKNOWN = 2'd3;
   localparam int CYCLE_LIMIT = 10000000;

   typedef struct packed {
      logic [tspl_pkg::ACTION_W-1:0]     action;
      logic [tspl_pkg::SLOT_FIELD_W-1:0] slot;
      logic [tspl_pkg::TIME_FIELD_W-1:0] expiry;
      logic [tspl_pkg::TIME_FIELD_W-1:0] now;
   } pool_req_type;

   // lowest field last, matching rsp_tdata
   typedef struct packed {
      logic [tspl_pkg::CNT_FIELD_W-1:0]  live;
      logic [tspl_pkg::CNT_FIELD_W-1:0]  freed;
      logic                              status;
      logic [tspl_pkg::SLOT_FIELD_W-1:0] evicted_slot;
      logic                              evicted;
      logic [tspl_pkg::SLOT_FIELD_W-1:0] granted;
   } pool_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [tspl_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [tspl_pkg::ACTION_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [tspl_pkg::RSP_DATA_W-1:0] rsp_tdata;

   timed_slot_pool_lru_evict DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #4 clock = ~clock;

   // shadow pool state
   int nxt[SLOTS];
   int prv[SLOTS];
   bit act[SLOTS];
   logic [tspl_pkg::TIME_FIELD_W-1:0] exp_at[SLOTS];
   int free_head, newest, oldest, live;

   pool_req_type pending_items[$];
   pool_rsp_type expected_rsps[$];
   int errors = 0;
   int cycles = 0;
   bit stim_done = 0;
   bit hold_rsp = 0;
   bit req_taken = 0;

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   function automatic void release_slot(int s);
      int nw, od;
      nw = prv[s];
      od = nxt[s];
      if (nw < SLOTS) nxt[nw] = od; else newest = od;
      if (od < SLOTS) prv[od] = nw; else oldest = nw;
      act[s] = 0;
      nxt[s] = free_head;
      free_head = s;
      if (live > 0) live--;
   endfunction

   function automatic pool_rsp_type predict_pool(pool_req_type r);
      pool_rsp_type o;
      int s, cur, nw, steps;
      o = '0;
      case (r.action)
         tspl_pkg::ACT_ALLOC: begin
            if (free_head >= SLOTS && oldest < SLOTS) begin
               o.evicted = 1'b1;
               o.evicted_slot = tspl_pkg::SLOT_FIELD_W'(oldest);
               release_slot(oldest);
            end
            if (free_head < SLOTS) begin
               s = free_head;
               free_head = nxt[s];
               act[s] = 1;
               exp_at[s] = r.expiry;
               nxt[s] = newest;
               prv[s] = NIL;
               if (newest < SLOTS) prv[newest] = s; else oldest = s;
               newest = s;
               live++;
               o.granted = tspl_pkg::SLOT_FIELD_W'(s);
            end
         end
         tspl_pkg::ACT_FREE: begin
            if (act[r.slot]) release_slot(int'(r.slot));
            else o.status = 1'b1;
         end
         tspl_pkg::ACT_SWEEP: begin
            cur = oldest;
            steps = 0;
            while (cur < SLOTS && steps < SLOTS) begin
               nw = prv[cur];
               if (exp_at[cur] <= r.now) begin
                  release_slot(cur);
                  o.freed++;
               end
               cur = nw;
               steps++;
            end
         end
         default: ;
      endcase
      o.live = tspl_pkg::CNT_FIELD_W'(live);
      return o;
   endfunction

   function automatic pool_req_type make_req(logic [tspl_pkg::ACTION_W-1:0] a, int sl,
                                             logic [tspl_pkg::TIME_FIELD_W-1:0] e,
                                             logic [tspl_pkg::TIME_FIELD_W-1:0] n);
      pool_req_type r;
      r.action = a; r.slot = tspl_pkg::SLOT_FIELD_W'(sl); r.expiry = e; r.now = n;
      return r;
   endfunction

   function automatic logic [tspl_pkg::TIME_FIELD_W-1:0] rand_word();
      return tspl_pkg::TIME_FIELD_W'($urandom);
   endfunction

   function automatic logic [tspl_pkg::TIME_FIELD_W-1:0] rand_time();
      return ($urandom_range(0, 3) == 0) ? rand_word()
                                         : tspl_pkg::TIME_FIELD_W'($urandom_range(0, 4000));
   endfunction

   // stimulus
   initial begin
      int burst;
      for (int i = 0; i < SLOTS; i++) begin
         nxt[i] = i + 1; prv[i] = 0; act[i] = 0; exp_at[i] = '0;
      end
      free_head = 0; newest = NIL; oldest = NIL; live = 0;

      // directed: edges, bad frees, unknown action, sweeps
      pending_items.push_back(make_req(tspl_pkg::ACT_FREE, 0, '0, '0));
      pending_items.push_back(make_req(tspl_pkg::ACT_SWEEP, 0, '0, '1));
      pending_items.push_back(make_req(ACT_UNKNOWN, '1, '1, '1));
      pending_items.push_back(make_req(tspl_pkg::ACT_ALLOC, 0, '1, '0));
      pending_items.push_back(make_req(tspl_pkg::ACT_ALLOC, '1, '0, '0));
      pending_items.push_back(make_req(tspl_pkg::ACT_ALLOC, 0, 31'd100, '0));
      pending_items.push_back(make_req(tspl_pkg::ACT_FREE, 1, '0, '0));
      pending_items.push_back(make_req(tspl_pkg::ACT_FREE, 1, '0, '0));
      pending_items.push_back(make_req(tspl_pkg::ACT_FREE, '1, '0, '0));
      pending_items.push_back(make_req(tspl_pkg::ACT_SWEEP, 0, '0, 31'd99));
      pending_items.push_back(make_req(tspl_pkg::ACT_SWEEP, 0, '0, 31'd100));
      pending_items.push_back(make_req(tspl_pkg::ACT_SWEEP, 0, '0, 31'h7FFF_FFFE));
      pending_items.push_back(make_req(tspl_pkg::ACT_SWEEP, 0, '0, '1));
      // build up a population of live slots
      for (int i = 0; i < 120; i++)
         pending_items.push_back(make_req(tspl_pkg::ACT_ALLOC, $urandom, rand_time(), '0));
      pending_items.push_back(make_req(tspl_pkg::ACT_SWEEP, 0, '0, 31'd2000));
      // random mix, mostly alloc and free of live-ish slots
      for (int i = 0; i < 566; i++) begin
         burst = $urandom_range(0, 99);
         if (burst < 45)
            pending_items.push_back(make_req(tspl_pkg::ACT_ALLOC, $urandom, rand_time(),
                                             rand_word()));
         else if (burst < 80)
            pending_items.push_back(make_req(tspl_pkg::ACT_FREE,
               ($urandom_range(0, 3) == 0) ? $urandom_range(0, SLOTS - 1)
                                            : $urandom_range(0, 63),
               rand_word(), rand_word()));
         else if (burst < 95)
            pending_items.push_back(make_req(tspl_pkg::ACT_SWEEP, $urandom, rand_word(),
                                             rand_time()));
         else
            pending_items.push_back(make_req(ACT_UNKNOWN, $urandom, rand_word(), rand_word()));
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // driver
   int req_wait = 0;
   always @(negedge clock) begin
      pool_req_type r;
      if (!reset) begin
         if (req_taken) begin
            r = pending_items.pop_front();
            expected_rsps.push_back(predict_pool(r));
            req_wait = $urandom_range(0, 1) ? 0 : $urandom_range(0, 9);
            if (pending_items.size() == 0) stim_done = 1;
         end
         if (req_wait > 0) begin
            req_wait--;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            r = pending_items[0];
            req_tvalid <= 1'b1;
            req_tuser <= r.action;
            req_tdata <= {7'b0, r.now, r.expiry, r.slot};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // long receiver hold-off early in the random part
   initial begin
      wait (!reset);
      repeat (3000) @(posedge clock);
      hold_rsp = 1;
      repeat (400) @(posedge clock);
      hold_rsp = 0;
   end

   // monitor and receiver stall
   int rsp_wait = 0;
   always @(posedge clock) begin
      pool_rsp_type got, want;
      cycles++;
      req_taken = !reset && req_tvalid && req_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_rsps.size() == 0) begin
            $display("unexpected result item");
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            if (got.granted != want.granted) report("granted_slot", got.granted, want.granted);
            if (got.evicted != want.evicted) report("evicted", got.evicted, want.evicted);
            if (got.evicted_slot != want.evicted_slot)
               report("evicted_slot", got.evicted_slot, want.evicted_slot);
            if (got.status != want.status) report("status", got.status, want.status);
            if (got.freed != want.freed) report("freed_count", got.freed, want.freed);
            if (got.live != want.live) report("live_count", got.live, want.live);
         end
         rsp_wait = $urandom_range(0, 1) ? 0 : $urandom_range(0, 9);
      end
   end

   always @(negedge clock) begin
      if (rsp_wait > 0 && !(rsp_tready && rsp_tvalid)) rsp_wait--;
      rsp_tready <= !reset && !hold_rsp && rsp_wait == 0;
   end

   // end of run
   initial begin
      wait (stim_done && expected_rsps.size() == 0);
      repeat (20000) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end
endmodule
`default_nettype wire

/* timed_slot_pool_lru_evict.f */
+incdir+rtl/core
rtl/core/tspl_pkg.sv
rtl/core/tspl_front.sv
rtl/core/tspl_queue.sv
rtl/core/tspl_engine.sv
rtl/core/timed_slot_pool_lru_evict.sv
rtl/core/tspl_checker.sv
tb/sv/testbench.sv
